[design/stsc_pkg.sv]
`default_nettype none

package stsc_pkg;

  // sync pattern, bit j is the pattern bit of tap j
  localparam int PAT_LEN = 65;
  localparam logic [PAT_LEN-1:0] SYNC_PATTERN =
    65'b00011_0110101110_1000110010_0010000001_0010011010_0111101110_0001111111;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_THRESHOLD = 1'b0;

  localparam int THRESHOLD_W = 7;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 7'd8;

  localparam int DIFFER_W = 7;
  localparam logic [DIFFER_W-1:0] DIFFER_MAX = 7'd127;

  // adder tree geometry
  localparam int GRP_BITS = 8;
  localparam int GRP_CNT_W = 4;
  localparam int GRP_FAN = 4;
  localparam int PART_W = 6;

endpackage

`default_nettype wire

[design/stsc_ram.sv]
`default_nettype none

module stsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/stsc_cell.sv]
`default_nettype none

module stsc_cell #(
  parameter int SPACING     = 80,
  parameter int SAMPLE_BITS = 16,
  parameter bit PATTERN_BIT = 1'b0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   shift_i,
  input  wire logic [SAMPLE_BITS-1:0] din_i,
  output logic      [SAMPLE_BITS-1:0] head_o,
  output logic                        differ_o
);

  localparam int PTR_W = (SPACING > 1) ? $clog2(SPACING) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SPACING - 1);

  logic [PTR_W-1:0]       ptr_q, ptr_d, raddr;
  logic                   wrapped_q, wrapped_d;
  logic                   fwd_q, fwd_d;
  logic [SAMPLE_BITS-1:0] fwd_data_q;
  logic [SAMPLE_BITS-1:0] rdata;

  always_comb begin
    ptr_d     = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
    wrapped_d = wrapped_q | (ptr_q == PTR_LAST);
    fwd_d     = shift_i && (ptr_d == ptr_q);
  end

  // prefetch the next oldest entry so the head is ready right after a shift
  assign raddr = shift_i ? ptr_d : ptr_q;

  stsc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(SPACING)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (shift_i),
    .waddr_i(ptr_q),
    .wdata_i(din_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
      if (shift_i) begin
        ptr_q     <= ptr_d;
        wrapped_q <= wrapped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      fwd_data_q <= din_i;
    end
  end

  // entries not yet written since reset read as zero samples
  always_comb begin
    if (!wrapped_q) begin
      head_o = '0;
    end else if (fwd_q) begin
      head_o = fwd_data_q;
    end else begin
      head_o = rdata;
    end
    differ_o = ~head_o[SAMPLE_BITS-1] ^ PATTERN_BIT;
  end

endmodule

`default_nettype wire

[design/stsc_popcnt.sv]
`default_nettype none

module stsc_popcnt #(
  parameter int N_BITS      = 65,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [N_BITS-1:0]              bits_i,
  input  wire logic [SAMPLE_BITS-1:0]         sample_i,
  output logic                                valid_o,
  output logic      [$clog2(N_BITS + 1)-1:0]  count_o,
  output logic      [SAMPLE_BITS-1:0]         sample_o
);

  localparam int CW = $clog2(N_BITS + 1);
  localparam int NG = (N_BITS + stsc_pkg::GRP_BITS - 1) / stsc_pkg::GRP_BITS;
  localparam int NP = (NG + stsc_pkg::GRP_FAN - 1) / stsc_pkg::GRP_FAN;
  localparam int NG_PAD = NP * stsc_pkg::GRP_FAN;
  localparam int NB_PAD = NG_PAD * stsc_pkg::GRP_BITS;

  logic [NB_PAD-1:0] padded;

  logic [stsc_pkg::GRP_CNT_W-1:0] grp_d [NG_PAD];
  logic [stsc_pkg::GRP_CNT_W-1:0] grp_q [NG_PAD];
  logic [stsc_pkg::PART_W-1:0]    part_d [NP];
  logic [stsc_pkg::PART_W-1:0]    part_q [NP];
  logic [CW-1:0]                  count_d;

  logic                   b_valid_q, c_valid_q;
  logic [SAMPLE_BITS-1:0] b_sample_q, c_sample_q;

  assign padded = NB_PAD'(bits_i);

  // stage b: popcount of each group of eight
  always_comb begin
    for (int g = 0; g < NG_PAD; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < stsc_pkg::GRP_BITS; k++) begin
        grp_d[g] = grp_d[g] + stsc_pkg::GRP_CNT_W'(padded[g*stsc_pkg::GRP_BITS + k]);
      end
    end
  end

  // stage c: sums of four group counts
  always_comb begin
    for (int h = 0; h < NP; h++) begin
      part_d[h] = '0;
      for (int k = 0; k < stsc_pkg::GRP_FAN; k++) begin
        part_d[h] = part_d[h] + stsc_pkg::PART_W'(grp_q[h*stsc_pkg::GRP_FAN + k]);
      end
    end
  end

  // stage d: final sum, each partial is no larger than the tap count
  always_comb begin
    count_d = '0;
    for (int h = 0; h < NP; h++) begin
      count_d = count_d + CW'(part_q[h]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= valid_i;
      c_valid_q <= b_valid_q;
      valid_o   <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q      <= grp_d;
      b_sample_q <= sample_i;
      part_q     <= part_d;
      c_sample_q <= b_sample_q;
      count_o    <= count_d;
      sample_o   <= c_sample_q;
    end
  end

endmodule

`default_nettype wire

[design/spaced_tap_sync_correlator.sv]
`default_nettype none

// Spaced-tap sync word correlator. Every sample word in gives one word out:
// the sample that entered TAP_COUNT*TAP_SPACING-1 words earlier, the number
// of taps whose hard bit (sample >= 0) differs from the 65-bit sync pattern,
// and frame_start when that count plus threshold reaches TAP_COUNT. The
// window is a chain of TAP_COUNT cells, each a TAP_SPACING-deep delay RAM
// that advances one word per accepted input, so a new word can enter every
// clock unless the output stalls. Results pass in order through the cell
// heads, read from RAM at the accepting edge itself, the pipelined tap count
// (group counts, partial sums, final count) and the output register. Stalls
// on the output hold the whole pipeline and back-pressure the input in the
// same cycle. After reset the window reads as zero samples with no clearing
// pass; the threshold register sits at byte address 0 and resets to 8.
module spaced_tap_sync_correlator #(
  parameter int TAP_COUNT   = 65,
  parameter int TAP_SPACING = 80,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [stsc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [stsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [stsc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,

  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       sample_i,

  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]            delayed_sample_o,
  output logic                                     frame_start_o,
  output logic      [stsc_pkg::DIFFER_W-1:0]       differ_count_o
);

  localparam int CW = $clog2(TAP_COUNT + 1);
  localparam int SUM_W = ((CW > stsc_pkg::THRESHOLD_W) ? CW : stsc_pkg::THRESHOLD_W) + 1;

  logic                               advance, accept;
  logic                               head_valid_q;
  logic [SAMPLE_BITS-1:0]             head [TAP_COUNT];
  logic [TAP_COUNT-1:0]               differ;
  logic [stsc_pkg::THRESHOLD_W-1:0]   threshold_q;
  logic                               cfg_wr;

  logic                               cnt_valid;
  logic [CW-1:0]                      cnt;
  logic [SAMPLE_BITS-1:0]             cnt_sample;
  logic [SUM_W-1:0]                   hit_sum;
  logic                               hit;
  logic [stsc_pkg::DIFFER_W-1:0]      differ_sat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[stsc_pkg::REG_IDX_BIT] == stsc_pkg::REG_THRESHOLD);

  always_comb begin
    if (paddr[stsc_pkg::REG_IDX_BIT] == stsc_pkg::REG_THRESHOLD) begin
      prdata = stsc_pkg::APB_DATA_W'(threshold_q);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= stsc_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      threshold_q <= pwdata[stsc_pkg::THRESHOLD_W-1:0];
    end
  end

  // whole pipeline holds while a finished word waits
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // cell c holds the tap TAP_COUNT-1-c, the oldest tap sits at the chain end
  for (genvar c = 0; c < TAP_COUNT; c++) begin : g_cell
    logic [SAMPLE_BITS-1:0] din;
    if (c == 0) begin : g_first
      assign din = sample_i;
    end else begin : g_next
      assign din = head[c-1];
    end

    stsc_cell #(
      .SPACING    (TAP_SPACING),
      .SAMPLE_BITS(SAMPLE_BITS),
      .PATTERN_BIT(stsc_pkg::SYNC_PATTERN[(TAP_COUNT - 1 - c) % stsc_pkg::PAT_LEN])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .din_i   (din),
      .head_o  (head[c]),
      .differ_o(differ[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else if (advance) begin
      head_valid_q <= accept;
    end
  end

  stsc_popcnt #(
    .N_BITS     (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_popcnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (head_valid_q),
    .bits_i  (differ),
    .sample_i(head[TAP_COUNT-1]),
    .valid_o (cnt_valid),
    .count_o (cnt),
    .sample_o(cnt_sample)
  );

  always_comb begin
    hit_sum = SUM_W'(cnt) + SUM_W'(threshold_q);
    hit     = hit_sum >= SUM_W'(TAP_COUNT);
    if (SUM_W'(cnt) > SUM_W'(stsc_pkg::DIFFER_MAX)) begin
      differ_sat = stsc_pkg::DIFFER_MAX;
    end else begin
      differ_sat = stsc_pkg::DIFFER_W'(cnt);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= cnt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      delayed_sample_o <= cnt_sample;
      frame_start_o    <= hit;
      differ_count_o   <= differ_sat;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int TAPS        = 65;
  localparam int SPACING     = 80;
  localparam int WIN_LEN     = TAPS * SPACING;
  localparam int SAMPLE_W    = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 920;

  // pattern bit j of tap j, tap 0 leftmost
  localparam bit [0:64] SYNC_BITS =
    65'b1111111000_0111011110_0101100100_1000000100_0100110001_0111010110_11000;

  localparam logic [stsc_pkg::APB_ADDR_W-1:0] THRESH_ADDR =
    stsc_pkg::APB_ADDR_W'(stsc_pkg::REG_THRESHOLD) << stsc_pkg::REG_IDX_BIT;

  // sample classes for the random segments
  typedef enum int {SEG_ANY, SEG_POS, SEG_NEG, SEG_EDGES} seg_kind_e;

  typedef struct {
    logic [SAMPLE_W-1:0]           delayed;
    logic                          start;
    logic [stsc_pkg::DIFFER_W-1:0] count;
  } corr_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [stsc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [stsc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [stsc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i = '0;

  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]    delayed_sample_o;
  logic                          frame_start_o;
  logic [stsc_pkg::DIFFER_W-1:0] differ_count_o;

  // predictor state
  logic [SAMPLE_W-1:0]              window_q [WIN_LEN];
  int                               head_idx;
  logic [stsc_pkg::THRESHOLD_W-1:0] thresh_model;

  corr_word_t expected_words[$];
  corr_word_t popped_word;

  int  mismatches;
  int  samples_sent;
  int  cycle_count;
  int  rx_wait;
  bit  idle_on;

  spaced_tap_sync_correlator #(
    .TAP_COUNT   (TAPS),
    .TAP_SPACING (SPACING),
    .SAMPLE_BITS (SAMPLE_W)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .delayed_sample_o (delayed_sample_o),
    .frame_start_o    (frame_start_o),
    .differ_count_o   (differ_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // shift one sample into the window and correlate the taps
  function automatic corr_word_t correlate_sample(input logic [SAMPLE_W-1:0] s);
    corr_word_t w;
    int pos;
    int cnt;
    int j;
    window_q[head_idx] = s;
    head_idx = (head_idx + 1) % WIN_LEN;
    pos = head_idx;
    cnt = 0;
    for (j = 0; j < TAPS; j++) begin
      cnt += int'(!window_q[pos][SAMPLE_W-1] ^ SYNC_BITS[j % stsc_pkg::PAT_LEN]);
      pos = (pos + SPACING) % WIN_LEN;
    end
    w.delayed = window_q[head_idx];
    w.start = (cnt + int'(thresh_model)) >= TAPS;
    w.count = (cnt > 127) ? stsc_pkg::DIFFER_MAX : stsc_pkg::DIFFER_W'(cnt);
    return w;
  endfunction

  // output side: random stall after each accepted word
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      rx_wait = idle_on ? $urandom_range(0, 9) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, sample %h", delayed_sample_o));
      end else begin
        popped_word = expected_words.pop_front();
        if (delayed_sample_o !== popped_word.delayed)
          report_mismatch($sformatf("delayed_sample got %h want %h",
                                    delayed_sample_o, popped_word.delayed));
        if (frame_start_o !== popped_word.start)
          report_mismatch($sformatf("frame_start got %b want %b",
                                    frame_start_o, popped_word.start));
        if (differ_count_o !== popped_word.count)
          report_mismatch($sformatf("differ_count got %0d want %0d",
                                    differ_count_o, popped_word.count));
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_words.push_back(correlate_sample(s));
    samples_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_threshold(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESH_ADDR;
    pwdata <= stsc_pkg::APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh_model = stsc_pkg::THRESHOLD_W'(value);
    @(posedge clk_i);
  endtask

  task automatic read_threshold();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= THRESH_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[stsc_pkg::THRESHOLD_W-1:0] !== thresh_model)
      report_mismatch($sformatf("threshold read got %0d want %0d",
                                prdata[stsc_pkg::THRESHOLD_W-1:0], thresh_model));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input seg_kind_e kind);
    logic [SAMPLE_W-1:0] s;
    case (kind)
      SEG_POS: s = SAMPLE_W'($urandom_range(0, 32767));
      SEG_NEG: s = 16'h8000 | SAMPLE_W'($urandom_range(0, 32767));
      SEG_EDGES: begin
        case ($urandom_range(0, 3))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = 16'h0000;
          default: s = 16'hffff;
        endcase
      end
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  // reset threshold, extremes and sign boundary on the zero-filled window
  task automatic test_reset_window();
    logic [SAMPLE_W-1:0] edges [10];
    int i;
    edges = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
              16'hfffe, 16'h5555, 16'haaaa, 16'h8001, 16'h7ffe};
    idle_on = 1'b0;
    read_threshold();
    for (i = 0; i < 10; i++) send_sample(edges[i]);
  endtask

  // threshold at zero, at the tap count and at the reset-window boundary
  task automatic test_threshold_limits();
    int settings [4];
    int i;
    int k;
    settings = '{0, 65, 32, 33};
    idle_on = 1'b1;
    for (i = 0; i < 4; i++) begin
      wait_results_done();
      write_threshold(settings[i]);
      read_threshold();
      for (k = 0; k < 4; k++) send_sample(pick_sample(seg_kind_e'(k)));
    end
  endtask

  // sender holds off until the output side has drained everything
  task automatic test_drain_pause();
    int i;
    idle_on = 1'b1;
    for (i = 0; i < 30; i++) send_sample(pick_sample(SEG_ANY));
    wait_results_done();
    for (i = 0; i < 30; i++) send_sample(pick_sample(SEG_ANY));
  endtask

  // segments of one sample class under changing thresholds and idling
  task automatic test_random_phases();
    int goal;
    int seg_len;
    int i;
    int pick;
    seg_kind_e kind;
    goal = samples_sent + RANDOM_ITEMS;
    while (samples_sent < goal) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_results_done();
        pick = $urandom_range(0, 7);
        if (pick == 0) write_threshold(0);
        else if (pick == 1) write_threshold(65);
        else write_threshold($urandom_range(28, 38));
        read_threshold();
      end
      idle_on = ($urandom_range(0, 3) != 0);
      kind = seg_kind_e'($urandom_range(0, 3));
      seg_len = $urandom_range(1, 80);
      for (i = 0; i < seg_len; i++) send_sample(pick_sample(kind));
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < WIN_LEN; i++) window_q[i] = '0;
    head_idx = 0;
    thresh_model = stsc_pkg::THRESHOLD_RESET;
    mismatches = 0;
    samples_sent = 0;
    cycle_count = 0;
    rx_wait = 0;
    idle_on = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_threshold_limits();
    test_drain_pause();
    test_random_phases();

    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
design/stsc_pkg.sv
design/stsc_ram.sv
design/stsc_cell.sv
design/stsc_popcnt.sv
design/spaced_tap_sync_correlator.sv
tb/sv/tb_top.sv
